// ===== design/assert_macros.svh =====
// Assertion macros shared by the wu line rasterizer RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define WU_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define WU_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/wu_line_pkg.sv =====
// Package for the wu antialiased line rasterizer: widths, codes, types, helpers.
// No dependencies; every other design file but assert_macros.svh imports it.
`timescale 1ns / 1ps
`default_nettype none

package wu_line_pkg;

    localparam int COORD_BITS = 13;
    localparam int FRAC_BITS  = 16;
    localparam int ALPHA_BITS = 8;

    localparam int PIX_BITS     = COORD_BITS - 1;          // output column/row
    localparam int CW           = COORD_BITS + 2;          // internal signed coordinate
    localparam int MAG_BITS     = COORD_BITS + 1;          // |dx|, |dy|
    localparam int QUO_BITS     = FRAC_BITS + 1;           // |slope| up to 1.0
    localparam int SLOPE_BITS   = FRAC_BITS + 2;
    localparam int POS_BITS     = COORD_BITS + FRAC_BITS + 1;
    localparam int Q_BITS       = FRAC_BITS + 1;           // coverage fraction 0..1.0
    localparam int DIV_CNT_BITS = $clog2(QUO_BITS);

    localparam int ALPHA_SHR = (FRAC_BITS >= ALPHA_BITS) ? FRAC_BITS - ALPHA_BITS : 0;
    localparam int ALPHA_SHL = (ALPHA_BITS > FRAC_BITS) ? ALPHA_BITS - FRAC_BITS : 0;
    localparam int A_WIDE    = Q_BITS + ALPHA_SHL;

    localparam logic [Q_BITS-1:0]     Q_ONE     = Q_BITS'(1) << FRAC_BITS;
    localparam logic [Q_BITS-1:0]     Q_HALF    = Q_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [ALPHA_BITS-1:0] ALPHA_MAX = '1;

    localparam logic [COORD_BITS-1:0] SCREEN_CAP        = COORD_BITS'(1) << (COORD_BITS - 1);
    localparam logic [COORD_BITS-1:0] SCREEN_WIDTH_RST  = COORD_BITS'(640);
    localparam logic [COORD_BITS-1:0] SCREEN_HEIGHT_RST = COORD_BITS'(480);

    // configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic                start;
        logic [MAG_BITS-1:0] num;
        logic [MAG_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [QUO_BITS-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic                 valid;
        logic                 steep;
        logic signed [CW-1:0] major;
        logic signed [CW-1:0] minor;
        logic [Q_BITS-1:0]    frac_q;
        logic                 last;
    } pix_cand_t;

    // Scale a fraction of one to alpha, truncating, saturated at full.
    function automatic logic [ALPHA_BITS-1:0] to_alpha(input logic [Q_BITS-1:0] q);
        logic [A_WIDE-1:0] w;
        w = A_WIDE'(q) << ALPHA_SHL;
        w = w >> ALPHA_SHR;
        if (w > A_WIDE'(ALPHA_MAX))
            return ALPHA_MAX;
        return w[ALPHA_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/wu_line_if.sv =====
// Handshake interfaces of the wu line rasterizer: line items, pixels, config writes.
// Depends on wu_line_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wu_in_if import wu_line_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, operation, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, operation, start_x, start_y, end_x, end_y, output ready);
endinterface

interface wu_pix_if import wu_line_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PIX_BITS-1:0]   pixel_x;
    logic [PIX_BITS-1:0]   pixel_y;
    logic [ALPHA_BITS-1:0] coverage;
    logic                  last;

    modport source (output valid, pixel_x, pixel_y, coverage, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, coverage, last, output ready);
endinterface

interface wu_cfg_if import wu_line_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [COORD_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/wu_antialiased_line_raster_top.sv =====
// Top level of the wu antialiased line rasterizer: sequencer and line state.
// Depends on wu_line_pkg, wu_line_if, wu_line_div, wu_line_pix_out, assert_macros.svh.
//
//  port       dir   payload                                  moves
//  ---------  ----  ---------------------------------------  ---------------------------
//  line_in    sink  operation, start_x, start_y, end_x, end_y one start or step command
//  pixel_out  src   pixel_x, pixel_y, coverage, last         one covered pixel
//  cfg        sink  index, data                              one screen register write
//
// A start transaction is accepted in idle, orients the endpoints (S_ORIENT, S_PREP),
// waits on the divider (one quotient bit per cycle into a 17-bit quotient, plus its
// result register; skipped when both endpoints coincide), seeds in S_SEED and emits
// its four endpoint pixels, one per cycle taken by the output register while
// pixel_out is ready. A step transaction is accepted and emits its pixel pair. line_in
// is ready only in idle; a stalled pixel_out holds the sequencer in its emit state.
// Reset is asynchronous; it clears control state and loads 640 x 480. cfg never stalls.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wu_antialiased_line_raster_top
    import wu_line_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    wu_in_if.sink     line_in,
    wu_pix_if.source  pixel_out,
    wu_cfg_if.sink    cfg
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ORIENT = 3'd1;
    localparam logic [2:0] S_PREP   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_SEED   = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    localparam logic signed [SLOPE_BITS-1:0] SLOPE_ONE = SLOPE_BITS'(Q_ONE);

    // control state
    logic [2:0]            state_reg, state_next;
    logic                  kind_reg, kind_next;     // OP_START or OP_STEP being emitted
    logic [1:0]            idx_reg, idx_next;       // pixel within the transaction
    logic                  active_reg, active_next;
    logic                  steep_reg, steep_next;
    logic [COORD_BITS-1:0] width_reg, width_next;
    logic [COORD_BITS-1:0] height_reg, height_next;

    // datapath state: endpoints hold raw coordinates until oriented, then
    // major (x) / minor (y) coordinates ordered along the major axis
    logic signed [COORD_BITS-1:0] p1x_reg, p1x_next;
    logic signed [COORD_BITS-1:0] p1y_reg, p1y_next;
    logic signed [COORD_BITS-1:0] p2x_reg, p2x_next;
    logic signed [COORD_BITS-1:0] p2y_reg, p2y_next;
    logic signed [COORD_BITS:0]   cur_reg, cur_next;
    logic signed [COORD_BITS-1:0] stop_reg, stop_next;
    logic signed [POS_BITS-1:0]   pos_reg, pos_next;
    logic signed [SLOPE_BITS-1:0] slope_reg, slope_next;
    logic                         dy_neg_reg, dy_neg_next;

    // orientation
    logic signed [COORD_BITS:0]   dxr, dyr;
    logic [MAG_BITS-1:0]          adx, ady;
    logic                         steep_c, swap_c;
    logic signed [COORD_BITS-1:0] a1, b1, a2, b2;

    // setup
    logic [MAG_BITS-1:0]        dx_mag, dy_mag;
    logic signed [COORD_BITS:0] dy_s;

    // emission
    logic signed [CW-1:0]   fl, minor_base, cur_inc;
    logic [FRAC_BITS-1:0]   frac;
    logic                   step_fin, start_fin, last_idx;

    logic      in_hs;
    div_req_t  div_req;
    div_rsp_t  div_rsp;
    pix_cand_t cand;
    logic      take;
    logic [COORD_BITS-1:0] width_cap, height_cap;

    assign line_in.ready = (state_reg == S_IDLE);
    assign in_hs         = line_in.valid && line_in.ready;
    assign cfg.ready     = 1'b1;

    // clip bounds never exceed what the output fields can address
    assign width_cap  = (width_reg  > SCREEN_CAP) ? SCREEN_CAP : width_reg;
    assign height_cap = (height_reg > SCREEN_CAP) ? SCREEN_CAP : height_reg;

    // steep test on raw endpoints, axis swap, then order by major axis
    assign dxr     = p2x_reg - p1x_reg;
    assign dyr     = p2y_reg - p1y_reg;
    assign adx     = dxr[COORD_BITS] ? MAG_BITS'(-dxr) : MAG_BITS'(dxr);
    assign ady     = dyr[COORD_BITS] ? MAG_BITS'(-dyr) : MAG_BITS'(dyr);
    assign steep_c = ady > adx;
    assign a1      = steep_c ? p1y_reg : p1x_reg;
    assign b1      = steep_c ? p1x_reg : p1y_reg;
    assign a2      = steep_c ? p2y_reg : p2x_reg;
    assign b2      = steep_c ? p2x_reg : p2y_reg;
    assign swap_c  = a1 > a2;

    // oriented deltas: dx >= 0 and |dy| <= dx, so the quotient stays within 1.0
    assign dx_mag = MAG_BITS'(dxr);
    assign dy_s   = dyr;
    assign dy_mag = dy_s[COORD_BITS] ? MAG_BITS'(-dy_s) : MAG_BITS'(dy_s);

    assign div_req.start = (state_reg == S_PREP) && (dx_mag != '0);
    assign div_req.num   = dy_mag;
    assign div_req.den   = dx_mag;

    wu_line_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // intery split: floor toward minus infinity and the fraction left over
    assign fl        = CW'(pos_reg >>> FRAC_BITS);
    assign frac      = pos_reg[FRAC_BITS-1:0];
    assign cur_inc   = CW'(cur_reg) + CW'(1);
    assign step_fin  = cur_inc >= CW'(stop_reg);
    assign start_fin = !(cur_reg < stop_reg);
    assign last_idx  = (kind_reg == OP_STEP) ? (idx_reg == 2'd1) : (idx_reg == 2'd3);

    assign minor_base = (kind_reg == OP_STEP) ? fl
                      : (idx_reg[1] ? CW'(p2y_reg) : CW'(p1y_reg));

    always_comb
    begin
        cand.valid = (state_reg == S_EMIT);
        cand.steep = steep_reg;
        if (kind_reg == OP_STEP)
        begin
            cand.major  = CW'(cur_reg);
            cand.frac_q = idx_reg[0] ? {1'b0, frac} : (Q_ONE - {1'b0, frac});
            cand.last   = step_fin;
        end
        else
        begin
            cand.major  = idx_reg[1] ? CW'(p2x_reg) : CW'(p1x_reg);
            cand.frac_q = idx_reg[0] ? '0 : Q_HALF;
            cand.last   = idx_reg[1] && start_fin;
        end
        // second pixel of each pair sits one row/column further on the minor axis
        cand.minor = minor_base + (idx_reg[0] ? CW'(1) : CW'(0));
    end

    wu_line_pix_out u_pix_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand       (cand),
        .width_cap  (width_cap),
        .height_cap (height_cap),
        .take       (take),
        .pixel_out  (pixel_out)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        steep_next  = steep_reg;
        width_next  = width_reg;
        height_next = height_reg;
        p1x_next    = p1x_reg;
        p1y_next    = p1y_reg;
        p2x_next    = p2x_reg;
        p2y_next    = p2y_reg;
        cur_next    = cur_reg;
        stop_next   = stop_reg;
        pos_next    = pos_reg;
        slope_next  = slope_reg;
        dy_neg_next = dy_neg_reg;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SCREEN_WIDTH:  width_next  = cfg.data;
                REG_SCREEN_HEIGHT: height_next = cfg.data;
                default:           width_next  = width_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_hs)
                begin
                    if (line_in.operation == OP_START)
                    begin
                        p1x_next   = line_in.start_x;
                        p1y_next   = line_in.start_y;
                        p2x_next   = line_in.end_x;
                        p2y_next   = line_in.end_y;
                        state_next = S_ORIENT;
                    end
                    else if (active_reg)
                    begin
                        // step on an idle line is dropped silently
                        kind_next  = OP_STEP;
                        idx_next   = 2'd0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_ORIENT:
            begin
                steep_next = steep_c;
                p1x_next   = swap_c ? a2 : a1;
                p1y_next   = swap_c ? b2 : b1;
                p2x_next   = swap_c ? a1 : a2;
                p2y_next   = swap_c ? b1 : b2;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cur_next    = (COORD_BITS+1)'(p1x_reg) + (COORD_BITS+1)'(1);
                stop_next   = p2x_reg;
                dy_neg_next = dy_s[COORD_BITS];
                if (dx_mag == '0)
                begin
                    // coincident endpoints: slope taken as 1.0
                    slope_next = SLOPE_ONE;
                    state_next = S_SEED;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    slope_next = dy_neg_reg ? -SLOPE_BITS'(div_rsp.quo)
                                            : SLOPE_BITS'(div_rsp.quo);
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                pos_next   = (POS_BITS'(p1y_reg) <<< FRAC_BITS) + POS_BITS'(slope_reg);
                kind_next  = OP_START;
                idx_next   = 2'd0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (take)
                begin
                    if (last_idx)
                    begin
                        state_next = S_IDLE;
                        if (kind_reg == OP_STEP)
                        begin
                            cur_next    = cur_reg + (COORD_BITS+1)'(1);
                            pos_next    = pos_reg + POS_BITS'(slope_reg);
                            active_next = !step_fin;
                        end
                        else
                        begin
                            active_next = !start_fin;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kind_reg   <= OP_START;
            idx_reg    <= 2'd0;
            active_reg <= 1'b0;
            steep_reg  <= 1'b0;
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            idx_reg    <= idx_next;
            active_reg <= active_next;
            steep_reg  <= steep_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1x_reg    <= p1x_next;
        p1y_reg    <= p1y_next;
        p2x_reg    <= p2x_next;
        p2y_reg    <= p2y_next;
        cur_reg    <= cur_next;
        stop_reg   <= stop_next;
        pos_reg    <= pos_next;
        slope_reg  <= slope_next;
        dy_neg_reg <= dy_neg_next;
    end

    `WU_ASSERT_IMP(a_div_done_waited, div_rsp.done, state_reg == S_DIV, "divider result arrived outside the divide wait")
    `WU_ASSERT_IMP(a_step_two_pixels, (state_reg == S_EMIT) && (kind_reg == OP_STEP), !idx_reg[1], "step transaction ran past its pixel pair")
    `WU_ASSERT_IMP(a_slope_in_range, state_reg == S_SEED, (slope_reg <= SLOPE_ONE) && (slope_reg >= -SLOPE_ONE), "slope magnitude above one")
    `WU_ASSERT_IMP(a_line_ends_idle, $fell(active_reg), state_reg == S_IDLE, "line closed outside idle")
    `WU_ASSERT_NXT(a_start_orients, in_hs && (line_in.operation == OP_START), state_reg == S_ORIENT, "start transaction did not enter orientation")

endmodule

`default_nettype wire

// ===== design/wu_line_div.sv =====
// Iterative restoring divider: |dy| * 2^FRAC_BITS / dx, one quotient bit per cycle.
// Depends on wu_line_pkg. Requires num <= den and den != 0.
`timescale 1ns / 1ps
`default_nettype none

module wu_line_div
    import wu_line_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [MAG_BITS:0]       rem_reg, rem_next;
    logic [QUO_BITS-1:0]     quo_reg, quo_next;
    logic [MAG_BITS-1:0]     den_reg, den_next;

    logic [MAG_BITS:0] trial;
    logic              ge;

    // first bit weighs 1.0 and takes no shift
    assign trial = (cnt_reg == '0) ? rem_reg : (rem_reg << 1);
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, req.num};
            quo_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (trial - {1'b0, den_reg}) : trial;
            quo_next = {quo_reg[QUO_BITS-2:0], ge};
            if (cnt_reg == DIV_CNT_BITS'(QUO_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

// ===== design/wu_line_pix_out.sv =====
// Pixel output stage: axis swap back, screen clip, alpha scaling, output register.
// Depends on wu_line_pkg and wu_line_if.
`timescale 1ns / 1ps
`default_nettype none

module wu_line_pix_out
    import wu_line_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pix_cand_t             cand,
    input  wire logic [COORD_BITS-1:0] width_cap,
    input  wire logic [COORD_BITS-1:0] height_cap,
    output logic                       take,
    wu_pix_if.source                   pixel_out
);

    logic                  valid_reg, valid_next;
    logic [PIX_BITS-1:0]   px_reg, py_reg;
    logic [ALPHA_BITS-1:0] cov_reg;
    logic                  last_reg;

    logic signed [CW-1:0] sx, sy;
    logic                 on_screen;
    logic                 load;

    assign sx = cand.steep ? cand.minor : cand.major;
    assign sy = cand.steep ? cand.major : cand.minor;

    assign on_screen = !sx[CW-1] && !sy[CW-1]
                    && (sx[CW-2:0] < (CW-1)'(width_cap))
                    && (sy[CW-2:0] < (CW-1)'(height_cap));

    assign take = !valid_reg || pixel_out.ready;
    assign load = take && cand.valid && on_screen;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = cand.valid && on_screen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg   <= sx[PIX_BITS-1:0];
            py_reg   <= sy[PIX_BITS-1:0];
            cov_reg  <= to_alpha(cand.frac_q);
            last_reg <= cand.last;
        end
    end

    assign pixel_out.valid    = valid_reg;
    assign pixel_out.pixel_x  = px_reg;
    assign pixel_out.pixel_y  = py_reg;
    assign pixel_out.coverage = cov_reg;
    assign pixel_out.last     = last_reg;

endmodule

`default_nettype wire

// ===== dv/wu_pixel_check.sv =====
// Pixel checker for the wu antialiased line rasterizer: watches the line, pixel and
// cfg channels, predicts every covered pixel and compares it with the DUT output.
// Depends on wu_line_pkg and the handshake interfaces in wu_line_if.
`timescale 1ns / 1ps

module wu_pixel_check
    import wu_line_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    wu_in_if     line_mon,
    wu_pix_if    pix_mon,
    wu_cfg_if    cfg_mon,
    output int   fail_count,
    output int   pending,
    output int   pixel_count,
    output int   last_count
);

    localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
    localparam longint HALF_Q = ONE_Q / 2;
    localparam int     A_SHIFT = FRAC_BITS - ALPHA_BITS;

    typedef struct packed {
        logic [PIX_BITS-1:0]   x;
        logic [PIX_BITS-1:0]   y;
        logic [ALPHA_BITS-1:0] cov;
        logic                  last;
    } pixel_t;

    pixel_t expected_pixels[$];

    logic [COORD_BITS-1:0] width_reg;
    logic [COORD_BITS-1:0] height_reg;

    // line state, major/minor axis frame
    bit     running;
    bit     steep;
    longint column;
    longint end_column;
    longint intery;
    longint gradient;

    function automatic logic [ALPHA_BITS-1:0] coverage_of(longint q);
        longint a;
        a = (q < 0) ? 0 : q;
        a = a >>> A_SHIFT;
        if (a > longint'(ALPHA_MAX))
            return ALPHA_MAX;
        return a[ALPHA_BITS-1:0];
    endfunction

    // Map back to screen axes, clip, and queue the pixel.
    function automatic void queue_pixel(longint major, longint minor, longint q, bit fin);
        longint sx, sy, w, h;
        pixel_t p;
        sx = steep ? minor : major;
        sy = steep ? major : minor;
        w  = (width_reg  > SCREEN_CAP) ? longint'(SCREEN_CAP) : longint'(width_reg);
        h  = (height_reg > SCREEN_CAP) ? longint'(SCREEN_CAP) : longint'(height_reg);
        if (sx < 0 || sy < 0 || sx >= w || sy >= h)
            return;
        p.x    = sx[PIX_BITS-1:0];
        p.y    = sy[PIX_BITS-1:0];
        p.cov  = coverage_of(q);
        p.last = fin;
        expected_pixels.push_back(p);
    endfunction

    function automatic void plan_line(longint ax, longint ay, longint bx, longint by);
        longint adx, ady, t, dx, dy;
        bit     fin;
        adx = (bx > ax) ? bx - ax : ax - bx;
        ady = (by > ay) ? by - ay : ay - by;
        steep = (ady > adx);
        if (steep) begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
        end
        if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        dx = bx - ax;
        dy = by - ay;
        // coincident endpoints take a gradient of one
        gradient   = (dx == 0) ? ONE_Q : (dy * ONE_Q) / dx;
        intery     = ay * ONE_Q + gradient;
        column     = ax + 1;
        end_column = bx;
        running    = (column < end_column);
        fin        = !running;
        queue_pixel(ax, ay,     HALF_Q, 1'b0);
        queue_pixel(ax, ay + 1, 0,      1'b0);
        queue_pixel(bx, by,     HALF_Q, fin);
        queue_pixel(bx, by + 1, 0,      fin);
    endfunction

    function automatic void plan_column();
        longint fl, frac;
        bit     fin;
        fl   = intery >>> FRAC_BITS;
        frac = intery - (fl <<< FRAC_BITS);
        fin  = (column + 1 >= end_column);
        queue_pixel(column, fl,     ONE_Q - frac, fin);
        queue_pixel(column, fl + 1, frac,         fin);
        column += 1;
        intery += gradient;
        if (fin)
            running = 1'b0;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t ns: pixel %0d %s mismatch: expected %0d, actual %0d",
                     $time, pixel_count, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pixel_t want;
        if (!rst_n) begin
            width_reg   = SCREEN_WIDTH_RST;
            height_reg  = SCREEN_HEIGHT_RST;
            running     = 1'b0;
            steep       = 1'b0;
            column      = 0;
            end_column  = 0;
            intery      = 0;
            gradient    = 0;
            fail_count  = 0;
            pixel_count = 0;
            last_count  = 0;
            expected_pixels.delete();
            pending     = 0;
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                if (cfg_mon.index == REG_SCREEN_WIDTH)
                    width_reg = cfg_mon.data;
                else if (cfg_mon.index == REG_SCREEN_HEIGHT)
                    height_reg = cfg_mon.data;
            end
            if (line_mon.valid && line_mon.ready) begin
                if (line_mon.operation == OP_START)
                    plan_line(longint'(line_mon.start_x), longint'(line_mon.start_y),
                              longint'(line_mon.end_x), longint'(line_mon.end_y));
                else if (running)
                    plan_column();
            end
            if (pix_mon.valid && pix_mon.ready) begin
                if (expected_pixels.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: unexpected pixel: expected none, actual x=%0d y=%0d cov=%0d last=%0d",
                             $time, pix_mon.pixel_x, pix_mon.pixel_y, pix_mon.coverage,
                             pix_mon.last);
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x",  16'(want.x),    16'(pix_mon.pixel_x));
                    check_field("pixel_y",  16'(want.y),    16'(pix_mon.pixel_y));
                    check_field("coverage", 16'(want.cov),  16'(pix_mon.coverage));
                    check_field("last",     16'(want.last), 16'(pix_mon.last));
                end
                pixel_count++;
                if (pix_mon.last === 1'b1)
                    last_count++;
            end
            pending = expected_pixels.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the wu line rasterizer testbench: clock, reset, stimulus and verdict.
// Depends on wu_line_pkg, wu_line_if, wu_pixel_check and the DUT top level.
`timescale 1ns / 1ps

module testbench;
    import wu_line_pkg::*;

    // Even with the slowest start and the longest stall on each of its four pixels,
    // ~215 transactions land far below this.
    localparam int CYCLE_LIMIT   = 400000;
    // Quiet time after the last pixel: covers a start whose pixels all clip.
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 168;
    localparam int MAX_GAP       = 13;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    wu_in_if  line_if ();
    wu_pix_if pix_if ();
    wu_cfg_if cfg_if ();

    int fail_count;
    int pending;
    int pixel_count;
    int last_count;

    wu_antialiased_line_raster_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_in   (line_if),
        .pixel_out (pix_if),
        .cfg       (cfg_if)
    );

    wu_pixel_check pixel_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_mon    (line_if),
        .pix_mon     (pix_if),
        .cfg_mon     (cfg_if),
        .fail_count  (fail_count),
        .pending     (pending),
        .pixel_count (pixel_count),
        .last_count  (last_count)
    );

    // Stimulus bookkeeping. steps_left mirrors how many step transactions the
    // current line still acts on, so ignored steps are not counted as work.
    bit quiet = 1'b0;          // both sides stop idling while set
    int steps_left   = 0;
    int starts_sent  = 0;
    int steps_sent   = 0;
    int settings_used = 1;     // reset values count as the first one
    int scr_w = 640;
    int scr_h = 480;
    int cycle_count = 0;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d pixels outstanding", cycle_count, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // Pixel sink: per pixel a random stall, none while quiet, then ready until that
    // pixel is taken. A zero stall keeps ready high across pixels.
    initial
    begin : pixel_sink
        int stall;
        pix_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                pix_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pix_if.ready <= 1'b1;
            do @(posedge clk); while (!(pix_if.valid && pix_if.ready));
            @(negedge clk);
        end
    end

    // One line transaction. Entered at a falling edge and left at the falling edge
    // after acceptance with valid still high, so back-to-back items need no dip.
    task automatic drive_item(input logic op,
                              input logic signed [COORD_BITS-1:0] ax,
                              input logic signed [COORD_BITS-1:0] ay,
                              input logic signed [COORD_BITS-1:0] bx,
                              input logic signed [COORD_BITS-1:0] by);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            line_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        line_if.valid     <= 1'b1;
        line_if.operation <= op;
        line_if.start_x   <= ax;
        line_if.start_y   <= ay;
        line_if.end_x     <= bx;
        line_if.end_y     <= by;
        do @(posedge clk); while (!line_if.ready);
        @(negedge clk);
    endtask

    task automatic send_line(input int ax, input int ay, input int bx, input int by);
        int adx, ady, major;
        adx   = (bx > ax) ? bx - ax : ax - bx;
        ady   = (by > ay) ? by - ay : ay - by;
        major = (ady > adx) ? ady : adx;
        steps_left = (major > 1) ? major - 1 : 0;
        starts_sent++;
        drive_item(OP_START, COORD_BITS'(ax), COORD_BITS'(ay), COORD_BITS'(bx),
                   COORD_BITS'(by));
    endtask

    // Step fields are don't-care; drive them random anyway.
    task automatic send_step();
        if (steps_left > 0)
        begin
            steps_left--;
            steps_sent++;
        end
        drive_item(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                   COORD_BITS'($urandom), COORD_BITS'($urandom));
    endtask

    // Hold the line channel until every predicted pixel has come out.
    task automatic drain_pause();
        line_if.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // Screen registers change only with the block idle: drain, then give a start
    // whose pixels were all clipped time to finish internally.
    task automatic set_screen(input int w, input int h);
        drain_pause();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_SCREEN_WIDTH;
        cfg_if.data  <= COORD_BITS'(w);
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.index <= REG_SCREEN_HEIGHT;
        cfg_if.data  <= COORD_BITS'(h);
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        scr_w = w;
        scr_h = h;
        settings_used++;
    endtask

    // Mostly near the screen, a quarter anywhere in range (margin left for length).
    function automatic int pick_coord(input int lim);
        if ($urandom_range(0, 3) == 0)
            return int'($urandom_range(0, 8071)) - 4036;
        return int'($urandom_range(0, ((lim < 4000) ? lim : 4000) + 32)) - 16;
    endfunction

    // Well-formed line: start plus its interior steps. Now and then the line is
    // abandoned early or followed by a step past its end.
    task automatic random_line();
        int len, off, dmaj, dmin, ax, ay, bx, by, n;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        off  = $urandom_range(0, len);
        dmaj = $urandom_range(0, 1) ? len : -len;
        dmin = $urandom_range(0, 1) ? off : -off;
        ax   = pick_coord(scr_w);
        ay   = pick_coord(scr_h);
        if ($urandom_range(0, 1))
        begin
            bx = ax + dmin;
            by = ay + dmaj;
        end
        else
        begin
            bx = ax + dmaj;
            by = ay + dmin;
        end
        send_line(ax, ay, bx, by);
        n = steps_left;
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(0, n);
        repeat (n) send_step();
        if ($urandom_range(0, 9) == 0)
            send_step();
    endtask

    // Noise: a full-range start (long line, usually abandoned) or a lone step.
    task automatic noise_item();
        if ($urandom_range(0, 1))
        begin
            send_line(int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096,
                      int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096);
            repeat ($urandom_range(0, 3)) send_step();
        end
        else
            send_step();
    endtask

    initial
    begin : stimulus
        int p;
        int target;
        line_if.valid     = 1'b0;
        line_if.operation = OP_START;
        line_if.start_x   = '0;
        line_if.start_y   = '0;
        line_if.end_x     = '0;
        line_if.end_y     = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = REG_SCREEN_WIDTH;
        cfg_if.data       = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part, reset screen of 640 x 480 ----
        // step with no line running: ignored
        send_step();
        // coincident endpoints: same pair twice, last on the second
        send_line(5, 5, 5, 5);
        // shallow line, gradient one half, then one step past the end
        send_line(0, 0, 4, 2);
        repeat (3) send_step();
        send_step();
        // steep, given back to front
        send_line(12, 9, 10, 5);
        repeat (3) send_step();
        // falling gradient, partly off the top-left corner
        send_line(-3, -2, 1, -4);
        repeat (3) send_step();
        // adjacent endpoints: no interior columns
        send_line(0, 0, 1, 0);
        // coordinate extremes, both diagonals; each abandoned by the next start
        send_line(-4096, -4096, 4095, 4095);
        repeat (2) send_step();
        send_line(4095, -4096, -4096, 4095);
        send_step();
        // steep line at the bottom-right clip edges
        send_line(639, 479, 638, 475);
        repeat (3) send_step();

        // ---- random part over several screen settings ----
        for (p = 0; p < 4; p++)
        begin
            case (p)
                0: set_screen(4096, 4096);
                1: set_screen(1, 1);
                2: set_screen($urandom_range(1, 4096), $urandom_range(1, 4096));
                default: set_screen($urandom_range(16, 200), $urandom_range(16, 200));
            endcase
            target = starts_sent + steps_sent + RANDOM_ITEMS / 4;
            while (starts_sent + steps_sent < target)
            begin
                if ($urandom_range(0, 5) == 0)
                    quiet = !quiet;
                if ($urandom_range(0, 14) == 0)
                    drain_pause();
                if ($urandom_range(0, 4) == 0)
                    noise_item();
                else
                    random_line();
            end
        end

        // ---- wind down ----
        quiet = 1'b0;
        drain_pause();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d starts and %0d column steps over %0d screen settings",
                 starts_sent, steps_sent, settings_used);
        $display("Checked %0d pixels, %0d of them flagged as line end", pixel_count, last_count);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
